/* src/gbn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and helpers of the go-back-n sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int DEF_BUFFER_DEPTH = 512;
   localparam int DEF_MAX_WINDOW   = 16;

   localparam int WS_W    = 5;
   localparam int TMO_W   = 16;
   localparam int WORD_W  = 32;
   localparam int LO_W    = 64;
   localparam int MID_W   = 64;
   localparam int HI_W    = 32;
   localparam int PAY_W   = LO_W + MID_W + HI_W;
   localparam int SEQ_W   = 9;
   localparam int BSUM_W  = 13;
   localparam int GRP_N   = PAY_W / 32;

   localparam int REQ_DATA_W = 3 * WORD_W + PAY_W;
   localparam int RSP_BITS   = SEQ_W + WORD_W + PAY_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [WS_W-1:0]  WINDOW_RESET  = 5'd5;
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd20;

   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_MSG  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT     = 1'd1;

   typedef struct packed {
      logic [HI_W-1:0]   hi;
      logic [MID_W-1:0]  mid;
      logic [LO_W-1:0]   lo;
      logic [WORD_W-1:0] check;
      logic [SEQ_W-1:0]  seq;
      logic              last;
   } rsp_entry_type;

   // Sum of the 20 payload bytes, each read as a signed byte.
   function automatic logic signed [BSUM_W-1:0] byte_sum(input logic [PAY_W-1:0] p);
      logic signed [BSUM_W-1:0] grp [GRP_N];
      logic signed [BSUM_W-1:0] s;
      s = '0;
      for (int g = 0; g < GRP_N; g++) begin
         grp[g] = '0;
         for (int b = 0; b < 4; b++) begin
            grp[g] = grp[g] + BSUM_W'(signed'(p[32*g + 8*b +: 8]));
         end
      end
      for (int g = 0; g < GRP_N; g++) begin
         s = s + grp[g];
      end
      return s;
   endfunction

endpackage

/* src/gbn_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module gbn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/go_back_n_sender_unit.sv */
`timescale 1ns / 1ps
// An accepted word goes through a checksum step and a window update step; the data packets
// it sends are then read from the payload RAM and pass through the output stage.
// Throughput: one packet per cycle from the payload RAM read port while the output is
// taken, up to one window of packets per word; the next word waits until all reads are issued.
// Reset clears counters, timer, output valids and the two registers to 5 and 20;
// the payload RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-back-n ARQ sender with NACK: stores messages, checks ACK/NACK packets,
// runs the retransmit timer and sends the packets of the window.
// ----------------------------------------------------------------------------
module go_back_n_sender_unit #(
   parameter int BUFFER_DEPTH = gbn_pkg::DEF_BUFFER_DEPTH,
   parameter int MAX_WINDOW   = gbn_pkg::DEF_MAX_WINDOW
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // ack_kind, ack_number, check_in, payload_lo, payload_mid, payload_hi
   input  logic [gbn_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic [gbn_pkg::CMD_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_seq, out_check, out_payload_lo, out_payload_mid, out_payload_hi, zero fill
   output logic [gbn_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gbn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gbn_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int WIN_W = $clog2(MAX_WINDOW + 1);
   localparam int END_W = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
   localparam int CMP_W = (WIN_W > WS_W) ? WIN_W : WS_W;
   localparam int MAG_W = WORD_W - 1;
   localparam int RAM_W = PAY_W + BSUM_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SUM    = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;
   localparam logic [1:0] S_SEND   = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [WS_W-1:0]          ws_ff;
   logic [TMO_W-1:0]         tmo_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         base_ff, base_in;
   logic                     running_ff, running_in;
   logic [TMO_W-1:0]         left_ff, left_in;
   logic [END_W-1:0]         ptr_ff, ptr_in;
   logic [END_W-1:0]         end_ff, end_in;

   logic [CMD_W-1:0]         cmd_ff;
   logic [WORD_W-1:0]        kind_ff, ackn_ff, chk_ff;
   logic [PAY_W-1:0]         pay_ff;
   logic signed [BSUM_W-1:0] bsum_ff;

   logic                     infl_ff;
   logic [IDX_W-1:0]         infl_idx_ff;
   logic                     infl_last_ff;

   rsp_entry_type            q0_ff, q1_ff, q0_in, q1_in, arr_entry;
   logic                     q0v_ff, q1v_ff, q0v_in, q1v_in;

   logic                     req_acc, pop, issue;
   logic [1:0]               occ;
   logic                     wr_en;
   logic [RAM_W-1:0]         rd_data;
   logic [WORD_W-1:0]        idx32;

   // Window and range arithmetic of the decide step.
   logic [WIN_W-1:0]         win;
   logic [END_W-1:0]         w_e, base_e, cnt_e, win_end, retx_to;
   logic                     chk_ok, stale, a_ge_cnt, a_gt_cnt;
   logic [MAG_W-1:0]         a_mag;
   logic [CNT_W-1:0]         nb;
   logic [END_W-1:0]         nb_e, nb_end, nb_to, ack_from;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      if (ws_ff == '0) begin
         win = WIN_W'(1);
      end else if (CMP_W'(ws_ff) > CMP_W'(MAX_WINDOW)) begin
         win = WIN_W'(MAX_WINDOW);
      end else begin
         win = WIN_W'(ws_ff);
      end
   end

   assign w_e     = END_W'(win);
   assign base_e  = END_W'(base_ff);
   assign cnt_e   = END_W'(count_ff);
   assign win_end = base_e + w_e;
   assign retx_to = (win_end < cnt_e) ? win_end : cnt_e;

   assign chk_ok   = (kind_ff + ackn_ff + WORD_W'(bsum_ff)) == chk_ff;
   assign a_mag    = ackn_ff[MAG_W-1:0];
   assign stale    = ackn_ff[WORD_W-1] || (a_mag < MAG_W'(base_ff));
   assign a_ge_cnt = a_mag >= MAG_W'(count_ff);
   assign a_gt_cnt = a_mag > MAG_W'(count_ff);

   always_comb begin
      if (kind_ff == '0) begin
         nb = a_ge_cnt ? count_ff : CNT_W'(a_mag + MAG_W'(1));
      end else begin
         nb = a_gt_cnt ? count_ff : CNT_W'(a_mag);
      end
   end

   assign nb_e     = END_W'(nb);
   assign nb_end   = nb_e + w_e;
   assign nb_to    = (nb_end < cnt_e) ? nb_end : cnt_e;
   assign ack_from = (win_end > nb_e) ? win_end : nb_e;

   // Decide step and send sequencer.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      base_in    = base_ff;
      running_in = running_ff;
      left_in    = left_ff;
      ptr_in     = ptr_ff;
      end_in     = end_ff;
      wr_en      = 1'b0;
      issue      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            unique case (cmd_ff)
               CMD_MSG: begin
                  if (count_ff != CNT_W'(BUFFER_DEPTH)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     if (cnt_e < win_end) begin
                        ptr_in   = cnt_e;
                        end_in   = cnt_e + END_W'(1);
                        state_in = S_SEND;
                        if (!running_ff) begin
                           running_in = 1'b1;
                           left_in    = tmo_ff;
                        end
                     end
                  end
               end
               CMD_ACK: begin
                  if (chk_ok && !stale) begin
                     base_in    = nb;
                     running_in = 1'b0;
                     if (kind_ff == '0) begin
                        if (nb < count_ff) begin
                           running_in = 1'b1;
                           left_in    = tmo_ff;
                        end
                        if (ack_from < nb_to) begin
                           ptr_in   = ack_from;
                           end_in   = nb_to;
                           state_in = S_SEND;
                        end
                     end else begin
                        running_in = 1'b1;
                        left_in    = tmo_ff;
                        if (nb_e < nb_to) begin
                           ptr_in   = nb_e;
                           end_in   = nb_to;
                           state_in = S_SEND;
                        end
                     end
                  end
               end
               CMD_TICK: begin
                  if (running_ff) begin
                     if (left_ff <= TMO_W'(1)) begin
                        left_in = tmo_ff;
                        if (base_e < retx_to) begin
                           ptr_in   = base_e;
                           end_in   = retx_to;
                           state_in = S_SEND;
                        end
                     end else begin
                        left_in = left_ff - TMO_W'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_SEND: begin
            // A read is issued only when the output queue has room for it.
            issue = (occ < 2'd2) || (occ == 2'd2 && pop);
            if (issue) begin
               ptr_in = ptr_ff + END_W'(1);
               if (ptr_ff + END_W'(1) == end_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   gbn_ram #(
      .WIDTH(RAM_W),
      .DEPTH(BUFFER_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data({bsum_ff, pay_ff}),
      .rd_en  (issue),
      .rd_addr(ptr_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   // Entry built from the RAM word that returns this cycle.
   assign idx32           = WORD_W'(infl_idx_ff);
   assign arr_entry.seq   = idx32[SEQ_W-1:0];
   assign arr_entry.check = idx32 + WORD_W'(signed'(rd_data[RAM_W-1:PAY_W]));
   assign arr_entry.lo    = rd_data[LO_W-1:0];
   assign arr_entry.mid   = rd_data[LO_W+MID_W-1:LO_W];
   assign arr_entry.hi    = rd_data[PAY_W-1:LO_W+MID_W];
   assign arr_entry.last  = infl_last_ff;

   assign pop = q0v_ff && rsp_tready;
   assign occ = 2'(q0v_ff) + 2'(q1v_ff) + 2'(infl_ff);

   // Two-entry output queue: q0 drives the port, q1 is the skid stage.
   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      q0v_in = q0v_ff;
      q1v_in = q1v_ff;
      case ({pop, infl_ff})
         2'b01: begin
            if (!q0v_ff) begin
               q0_in  = arr_entry;
               q0v_in = 1'b1;
            end else begin
               q1_in  = arr_entry;
               q1v_in = 1'b1;
            end
         end
         2'b10: begin
            q0_in  = q1_ff;
            q0v_in = q1v_ff;
            q1v_in = 1'b0;
         end
         2'b11: begin
            if (q1v_ff) begin
               q0_in = q1_ff;
               q1_in = arr_entry;
            end else begin
               q0_in = arr_entry;
            end
            q0v_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ws_ff      <= WINDOW_RESET;
         tmo_ff     <= TIMEOUT_RESET;
         count_ff   <= '0;
         base_ff    <= '0;
         running_ff <= 1'b0;
         left_ff    <= '0;
         infl_ff    <= 1'b0;
         q0v_ff     <= 1'b0;
         q1v_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         base_ff    <= base_in;
         running_ff <= running_in;
         left_ff    <= left_in;
         infl_ff    <= issue;
         q0v_ff     <= q0v_in;
         q1v_ff     <= q1v_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_WINDOW_SIZE: ws_ff  <= csr_data[WS_W-1:0];
               REG_TIMEOUT:     tmo_ff <= csr_data[TMO_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      end_ff <= end_in;
      q0_ff  <= q0_in;
      q1_ff  <= q1_in;
      if (req_acc) begin
         cmd_ff  <= req_tuser;
         kind_ff <= req_tdata[WORD_W-1:0];
         ackn_ff <= req_tdata[2*WORD_W-1:WORD_W];
         chk_ff  <= req_tdata[3*WORD_W-1:2*WORD_W];
         pay_ff  <= req_tdata[REQ_DATA_W-1:3*WORD_W];
      end
      if (state_ff == S_SUM) begin
         bsum_ff <= byte_sum(pay_ff);
      end
      if (issue) begin
         infl_idx_ff  <= ptr_ff[IDX_W-1:0];
         infl_last_ff <= (ptr_ff + END_W'(1) == end_ff);
      end
   end

   assign rsp_tvalid = q0v_ff;
   assign rsp_tlast  = q0_ff.last;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_BITS)'(0), q0_ff.hi, q0_ff.mid, q0_ff.lo,
                        q0_ff.check, q0_ff.seq};

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      occ <= 2'd2)
      else $error("output queue and read in flight exceed two entries");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      q1v_ff |-> q0v_ff)
      else $error("skid entry valid while head entry empty");

   a_base_le_count: assert property (@(posedge clock) disable iff (reset)
      base_ff <= count_ff)
      else $error("window base beyond stored count");

   a_send_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND) |-> (ptr_ff < end_ff && end_ff <= END_W'(count_ff)))
      else $error("send pointer outside the stored range");

   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      issue |=> (infl_ff && END_W'(infl_idx_ff) < END_W'(count_ff)))
      else $error("read of an entry not yet stored");

endmodule

/* bench/go_back_n_sender_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_unit_tb
// Self-checking bench for the go-back-n sender. A clocked driver feeds message,
// ACK/NACK and tick words from a queue, and a clocked monitor predicts the data
// packets that each accepted word sends and checks them in order.
// ----------------------------------------------------------------------------
module go_back_n_sender_unit_tb;
   import gbn_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int DIRECTED_N     = 22;
   localparam int PHASE_N        = 6;
   localparam int PHASE_WORDS    = 18;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [WORD_W-1:0] kind;
      logic [WORD_W-1:0] ackn;
      logic [WORD_W-1:0] chk;
      logic [LO_W-1:0]   lo;
      logic [MID_W-1:0]  mid;
      logic [HI_W-1:0]   hi;
   } req_word_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [CMD_W-1:0]        req_tuser  = CMD_MSG;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = REG_WINDOW_SIZE;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;

   req_word_type  pending_words[$];
   rsp_entry_type due_packets[$];
   int            errors      = 0;
   int            idle_cycles = 0;
   bit            quiet       = 1'b0;

   // Shadow state of the sender.
   logic [LO_W-1:0]  msg_lo  [DEF_BUFFER_DEPTH];
   logic [MID_W-1:0] msg_mid [DEF_BUFFER_DEPTH];
   logic [HI_W-1:0]  msg_hi  [DEF_BUFFER_DEPTH];
   int unsigned      mdl_count   = 0;
   int unsigned      mdl_base    = 0;
   bit               timer_on    = 1'b0;
   int unsigned      timer_left  = 0;
   logic [WS_W-1:0]  cfg_window  = WINDOW_RESET;
   logic [TMO_W-1:0] cfg_timeout = TIMEOUT_RESET;

   int unsigned win_set [PHASE_N] = '{1, 16, 0, 31, 7, 4};
   int unsigned tmo_set [PHASE_N] = '{1, 3, 0, 2, 65535, 5};

   go_back_n_sender_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // ack_kind, ack_number, check_in, payload_lo, payload_mid, payload_hi
      .req_tdata  (req_tdata),
      // cmd
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // out_seq, out_check, out_payload_lo, out_payload_mid, out_payload_hi
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------ model

   function automatic logic [31:0] payload_byte_total(input logic [LO_W-1:0] lo,
                                                      input logic [MID_W-1:0] mid,
                                                      input logic [HI_W-1:0] hi);
      logic [PAY_W-1:0] p;
      logic [31:0]      s;
      p = {hi, mid, lo};
      s = '0;
      for (int b = 0; b < 20; b++) begin
         s = s + {{24{p[8*b+7]}}, p[8*b +: 8]};
      end
      return s;
   endfunction

   function automatic int unsigned window_span();
      if (cfg_window == 0) return 1;
      if (cfg_window > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
      return cfg_window;
   endfunction

   task automatic arm_timer();
      timer_on   = 1'b1;
      timer_left = cfg_timeout;
   endtask

   task automatic push_packet(input int unsigned idx, input bit is_last);
      rsp_entry_type e;
      e.seq   = idx[SEQ_W-1:0];
      e.check = idx[31:0] + payload_byte_total(msg_lo[idx], msg_mid[idx], msg_hi[idx]);
      e.lo    = msg_lo[idx];
      e.mid   = msg_mid[idx];
      e.hi    = msg_hi[idx];
      e.last  = is_last;
      due_packets.push_back(e);
   endtask

   // Sends stored packets from..to-1, at most DEF_MAX_WINDOW of them per word.
   task automatic send_span(input int unsigned from, input int unsigned to);
      int unsigned stop;
      if (to > mdl_count) to = mdl_count;
      stop = to;
      if (from < to && to - from > DEF_MAX_WINDOW) stop = from + DEF_MAX_WINDOW;
      for (int unsigned i = from; i < stop; i++) begin
         push_packet(i, i == stop - 1);
      end
   endtask

   task automatic resend_window();
      arm_timer();
      send_span(mdl_base, mdl_base + window_span());
   endtask

   task automatic predict_sends(input logic [CMD_W-1:0] cmd, input logic [31:0] kind,
                                input logic [31:0] ackn, input logic [31:0] chk,
                                input logic [LO_W-1:0] lo, input logic [MID_W-1:0] mid,
                                input logic [HI_W-1:0] hi);
      int unsigned span, idx, old_end, from;
      longint      a, nb;
      logic [31:0] sum;
      span = window_span();
      a    = longint'($signed(ackn));
      sum  = kind + ackn + payload_byte_total(lo, mid, hi);
      case (cmd)
         CMD_MSG: begin
            if (mdl_count < DEF_BUFFER_DEPTH) begin
               idx          = mdl_count;
               msg_lo[idx]  = lo;
               msg_mid[idx] = mid;
               msg_hi[idx]  = hi;
               mdl_count    = idx + 1;
               if (idx < mdl_base + span) begin
                  push_packet(idx, 1'b1);
                  if (!timer_on) arm_timer();
               end
            end
         end
         CMD_ACK: begin
            if (sum == chk && a >= longint'(mdl_base)) begin
               timer_on = 1'b0;
               if (kind == 0) begin
                  old_end = mdl_base + span;
                  nb = a + 1;
                  if (nb > longint'(mdl_count)) nb = mdl_count;
                  mdl_base = nb;
                  if (mdl_base < mdl_count) arm_timer();
                  from = (old_end > mdl_base) ? old_end : mdl_base;
                  send_span(from, mdl_base + span);
               end else begin
                  nb = a;
                  if (nb > longint'(mdl_count)) nb = mdl_count;
                  mdl_base = nb;
                  resend_window();
               end
            end
         end
         CMD_TICK: begin
            if (timer_on) begin
               if (timer_left <= 1) resend_window();
               else timer_left = timer_left - 1;
            end
         end
         default: ;
      endcase
   endtask

   // -------------------------------------------------------------- stimulus

   function automatic req_word_type fresh_word(input logic [CMD_W-1:0] cmd);
      req_word_type w;
      w.cmd  = cmd;
      w.kind = $urandom;
      w.ackn = $urandom;
      w.chk  = $urandom;
      case ($urandom_range(0, 19))
         0: begin w.lo = '0; w.mid = '0; w.hi = '0; end
         1: begin w.lo = '1; w.mid = '1; w.hi = '1; end
         2: begin w.lo = {8{8'h80}}; w.mid = {8{8'h80}}; w.hi = {4{8'h80}}; end
         3: begin w.lo = {8{8'h7F}}; w.mid = {8{8'h7F}}; w.hi = {4{8'h7F}}; end
         default: begin
            w.lo  = {$urandom, $urandom};
            w.mid = {$urandom, $urandom};
            w.hi  = $urandom;
         end
      endcase
      return w;
   endfunction

   function automatic req_word_type ack_word(input logic [31:0] kind,
                                             input logic [31:0] ackn);
      req_word_type w;
      w      = fresh_word(CMD_ACK);
      w.kind = kind;
      w.ackn = ackn;
      w.chk  = kind + ackn + payload_byte_total(w.lo, w.mid, w.hi);
      return w;
   endfunction

   function automatic req_word_type directed_word(input int n);
      req_word_type w;
      w = fresh_word(CMD_MSG);
      case (n)
         0, 14, 15, 17: w.cmd = CMD_TICK;
         1:  w.cmd = CMD_SPARE;
         2:  begin w.lo = '0; w.mid = '0; w.hi = '0; end
         3:  begin w.lo = '1; w.mid = '1; w.hi = '1; end
         4:  begin w.lo = {8{8'h80}}; w.mid = {8{8'h80}}; w.hi = {4{8'h80}}; end
         5:  begin w.lo = {8{8'h7F}}; w.mid = {8{8'h7F}}; w.hi = {4{8'h7F}}; end
         9:  begin
            w = ack_word(32'd0, 32'd0);
            w.chk = w.chk ^ 32'd1;
         end
         10: w = ack_word(32'd0, 32'h8000_0000);
         11: w = ack_word(32'd0, 32'd0);
         12: w = ack_word(32'hFFFF_FFFF, 32'd2);
         13: w = ack_word(32'h8000_0000, mdl_base);
         16: w = ack_word(32'd0, 32'h7FFF_FFFF);
         19: w = ack_word(32'd0, mdl_count - 1);
         20: w = ack_word(32'd1, mdl_base);
         default: ;
      endcase
      return w;
   endfunction

   // Mostly well-formed traffic: messages, in-window ACK/NACKs and ticks,
   // with some corrupt packets and unused commands mixed in.
   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned  r, span;
      logic [31:0]  kind, ackn;
      r    = $urandom_range(0, 99);
      span = window_span();
      if (r < 40) begin
         w = fresh_word(CMD_MSG);
      end else if (r < 72) begin
         kind = ($urandom_range(0, 99) < 65) ? 32'd0 : $urandom;
         case ($urandom_range(0, 9))
            0:       ackn = mdl_base - 1;
            1:       ackn = mdl_count + $urandom_range(0, 3);
            2:       ackn = $urandom;
            default: ackn = mdl_base + $urandom_range(0, span);
         endcase
         w = ack_word(kind, ackn);
      end else if (r < 90) begin
         w = fresh_word(CMD_TICK);
      end else if (r < 95) begin
         w = ack_word($urandom, mdl_base + $urandom_range(0, span));
         w.chk = w.chk ^ (32'd1 << $urandom_range(0, 31));
      end else begin
         w = fresh_word(CMD_SPARE);
      end
      return w;
   endfunction

   task automatic wait_for_driver(input bit settled);
      while (pending_words.size() != 0 || (settled && req_tvalid)) @(posedge clock);
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_tvalid || due_packets.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_WINDOW_SIZE) cfg_window = val[WS_W-1:0];
      else cfg_timeout = val[TMO_W-1:0];
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words wait for the previous one so they can aim at the window.
      for (int n = 0; n < DIRECTED_N; n++) begin
         wait_for_driver(1'b1);
         pending_words.push_back(directed_word(n));
      end

      for (int p = 0; p < PHASE_N; p++) begin
         drain();
         write_reg(REG_WINDOW_SIZE, win_set[p]);
         write_reg(REG_TIMEOUT, tmo_set[p]);
         quiet = (p == 2);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            wait_for_driver(1'b0);
            pending_words.push_back(random_word());
         end
      end

      drain();
      if (errors == 0 && due_packets.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_req
      req_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 30)) begin
            w = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= w.cmd;
            req_tdata  <= {w.hi, w.mid, w.lo, w.chk, w.ackn, w.kind};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= 30);
      end
   end

   // --------------------------------------------------------------- monitor

   task automatic record_error(input string what, input rsp_entry_type want,
                               input rsp_entry_type got);
      errors++;
      if (errors <= 10) begin
         $display("%s: expected seq %0d check %h lo %h mid %h hi %h last %b", what,
                  want.seq, want.check, want.lo, want.mid, want.hi, want.last);
         $display("   got seq %0d check %h lo %h mid %h hi %h last %b",
                  got.seq, got.check, got.lo, got.mid, got.hi, got.last);
      end
   endtask

   // Results are checked before the word of the same edge is predicted; a
   // packet can never belong to a word accepted at the same edge.
   always @(posedge clock) begin : watch
      rsp_entry_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.seq   = rsp_tdata[0 +: SEQ_W];
            got.check = rsp_tdata[SEQ_W +: WORD_W];
            got.lo    = rsp_tdata[SEQ_W + WORD_W +: LO_W];
            got.mid   = rsp_tdata[SEQ_W + WORD_W + LO_W +: MID_W];
            got.hi    = rsp_tdata[SEQ_W + WORD_W + LO_W + MID_W +: HI_W];
            got.last  = rsp_tlast;
            if (due_packets.size() == 0) begin
               record_error("unexpected packet", '0, got);
            end else begin
               want = due_packets.pop_front();
               if (got !== want) record_error("packet mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_sends(req_tuser, req_tdata[0 +: WORD_W], req_tdata[WORD_W +: WORD_W],
                          req_tdata[2*WORD_W +: WORD_W], req_tdata[3*WORD_W +: LO_W],
                          req_tdata[3*WORD_W + LO_W +: MID_W],
                          req_tdata[3*WORD_W + LO_W + MID_W +: HI_W]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

/* go_back_n_sender_unit.f */
src/gbn_pkg.sv
src/gbn_ram.sv
src/go_back_n_sender_unit.sv
bench/go_back_n_sender_unit_tb.sv
